### rtl/psa_pkg.sv
// ----------------------------------------------------------------------------
// psa_pkg: shared types and constants of the slot allocator
// Register indexes, widths, the queue entry format and the back-end states.
// ----------------------------------------------------------------------------
package psa_pkg;

  localparam int unsigned MaxSockets = 8;
  localparam int unsigned SockW      = 3;
  localparam int unsigned AvgW       = 48;
  localparam int unsigned TotalW     = 52;
  localparam int unsigned CountW     = 32;
  localparam int unsigned CfgAddrW   = 2;
  localparam int unsigned CfgDataW   = 16;

  localparam logic [CfgAddrW-1:0] RegHistoryWeight = 2'd0;
  localparam logic [CfgAddrW-1:0] RegSocketsInUse  = 2'd1;
  localparam logic [CfgAddrW-1:0] RegTicks         = 2'd2;

  localparam logic [15:0] HistoryWeightReset = 16'd39322;
  localparam logic [3:0]  SocketsReset       = 4'd8;
  localparam logic [15:0] TicksReset         = 16'd250;

  // One classified count handed from the front end to the back end.
  typedef struct packed {
    logic [CountW-1:0] count;
    logic [SockW-1:0]  sock;
    logic              last;
  } entry_t;

  typedef enum logic [2:0] {
    BeLoad,
    BeBlend,
    BeDivInit,
    BeDivide,
    BeScale,
    BeEmit
  } be_state_e;

endpackage

### rtl/psa_front.sv
// ----------------------------------------------------------------------------
// psa_front: input stage of the slot allocator
// Replaces a zero count by one, tags each count with its socket and marks
// the count that completes a round.
// ----------------------------------------------------------------------------
module psa_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [31:0]           count_i,
  input  logic [3:0]            sockets_i,
  input  logic                  restart_i,
  output logic                  push_o,
  output psa_pkg::entry_t       entry_o,
  input  logic                  full_i
);
  import psa_pkg::*;

  logic [SockW-1:0] pos_q, pos_d;
  logic [3:0]       active;
  logic             last;

  // Sockets in use, held to the range one to the maximum.
  always_comb begin
    if (sockets_i == 4'd0) active = 4'd1;
    else if (sockets_i > 4'(MaxSockets)) active = 4'(MaxSockets);
    else active = sockets_i;
  end

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;
  assign last       = ({1'b0, pos_q} + 4'd1) >= active;

  assign entry_o.count = (count_i == 32'd0) ? 32'd1 : count_i;
  assign entry_o.sock  = pos_q;
  assign entry_o.last  = last;

  // Load position wraps after the last socket of a round.
  always_comb begin
    pos_d = pos_q;
    if (restart_i) pos_d = '0;
    else if (push_o) pos_d = last ? '0 : pos_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pos_q <= '0;
    else pos_q <= pos_d;
  end

endmodule

### rtl/psa_queue.sv
// ----------------------------------------------------------------------------
// psa_queue: short queue between the front end and the back end
// Two entries, first in first out.
// ----------------------------------------------------------------------------
module psa_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  psa_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output psa_pkg::entry_t entry_o
);
  import psa_pkg::*;

  entry_t     mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign entry_o = mem_q[rp_q];

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= entry_i;
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

### rtl/psa_back.sv
// ----------------------------------------------------------------------------
// psa_back: averaging and share computation of the slot allocator
// Buffers a round of counts, blends each into its average, sums the total,
// then divides each average by it bit by bit and scales to ticks.
// ----------------------------------------------------------------------------
module psa_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  empty_i,
  input  psa_pkg::entry_t       entry_i,
  output logic                  pop_o,
  input  logic [15:0]           weight_i,
  input  logic [15:0]           ticks_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [2:0]            sock_o,
  output logic [16:0]           share_o,
  output logic [15:0]           slot_o,
  output logic                  last_o
);
  import psa_pkg::*;

  be_state_e         state_q, state_d;
  logic [CountW-1:0] cbuf_q [MaxSockets];
  logic [AvgW-1:0]   avg_q [MaxSockets];
  logic [MaxSockets-1:0] avg_vld_q;
  logic [SockW-1:0]  last_sock_q, idx_q, idx_d;
  logic [TotalW-1:0] total_q;
  logic [TotalW:0]   rem_q;
  logic [16:0]       quo_q;
  logic [4:0]        bit_q;
  logic              phase_q;
  logic [63:0]       prod_q;
  logic              ov_q;
  logic [16:0]       o_share_q;
  logic [15:0]       o_slot_q;
  logic [SockW-1:0]  o_sock_q;
  logic              o_last_q, o_valid_q;

  logic [AvgW-1:0]   cur_avg;
  logic [AvgW-1:0]   fresh;
  logic [16:0]       wcomp;
  logic [48:0]       wprod;
  logic [64:0]       blend_sum;
  logic [AvgW-1:0]   blend_avg;
  logic [TotalW:0]   rem_sub;
  logic              take;
  logic              emit;

  assign cur_avg  = avg_vld_q[idx_q] ? avg_q[idx_q] : '0;
  assign fresh    = {cbuf_q[idx_q], 16'd0};
  assign wcomp    = 17'h10000 - {1'b0, weight_i};

  // Blended average: weighted old average plus the complement times the count, or the count alone at first.
  assign wprod     = 49'(wcomp) * 49'(cbuf_q[idx_q]);
  assign blend_sum = {1'b0, prod_q} + {wprod, 16'd0};
  assign blend_avg = ov_q ? blend_sum[63:16] : fresh;

  // One restoring step: subtract the total if it fits, then shift left.
  assign take     = rem_q >= {1'b0, total_q};
  assign rem_sub  = take ? rem_q - {1'b0, total_q} : rem_q;

  assign emit        = (state_q == BeEmit) && (!o_valid_q || out_ready_i);
  assign pop_o       = (state_q == BeLoad) && !empty_i;
  assign out_valid_o = o_valid_q;
  assign sock_o      = o_sock_q;
  assign share_o     = o_share_q;
  assign slot_o      = o_slot_q;
  assign last_o      = o_last_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      BeLoad: if (pop_o && entry_i.last) begin
        state_d = BeBlend;
        idx_d   = '0;
      end
      BeBlend: if (phase_q) begin
        if (idx_q == last_sock_q) begin
          state_d = BeDivInit;
          idx_d   = '0;
        end else idx_d = idx_q + 1'b1;
      end
      BeDivInit: state_d = BeDivide;
      BeDivide: if (bit_q == 5'd0) state_d = BeScale;
      BeScale: if (phase_q) state_d = BeEmit;
      BeEmit: if (!o_valid_q || out_ready_i) begin
        if (idx_q == last_sock_q) state_d = BeLoad;
        else begin
          state_d = BeDivInit;
          idx_d   = idx_q + 1'b1;
        end
      end
      default: state_d = BeLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BeLoad;
      idx_q     <= '0;
      avg_vld_q <= '0;
      total_q   <= '0;
      phase_q   <= 1'b0;
      o_valid_q <= 1'b0;
      bit_q     <= '0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      o_valid_q <= emit || (o_valid_q && !out_ready_i);
      unique case (state_q)
        BeLoad: begin
          phase_q <= 1'b0;
          if (pop_o && entry_i.last) total_q <= '0;
        end
        BeBlend: begin
          phase_q <= ~phase_q;
          if (phase_q) begin
            avg_vld_q[idx_q] <= 1'b1;
            total_q <= total_q + {4'd0, blend_avg};
          end
        end
        BeDivInit: bit_q <= 5'd16;
        BeDivide: begin
          phase_q <= 1'b0;
          if (bit_q != 5'd0) bit_q <= bit_q - 5'd1;
        end
        BeScale: phase_q <= ~phase_q;
        default: ;
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BeLoad: if (pop_o) begin
        cbuf_q[entry_i.sock] <= entry_i.count;
        last_sock_q <= entry_i.sock;
      end
      BeBlend: begin
        // Multiplies while phase_q is low, then sums and stores.
        if (!phase_q) begin
          prod_q <= 64'(weight_i) * 64'(cur_avg);
          ov_q   <= avg_vld_q[idx_q];
        end else begin
          avg_q[idx_q] <= blend_avg;
        end
      end
      BeDivInit: begin
        // The average never exceeds the total, so it seeds the remainder.
        rem_q <= {5'd0, cur_avg};
        quo_q <= '0;
      end
      BeDivide: begin
        rem_q <= {rem_sub[TotalW-1:0], 1'b0};
        quo_q <= {quo_q[15:0], take};
      end
      BeScale: begin
        if (!phase_q) prod_q <= 64'(quo_q) * 64'(ticks_i);
      end
      BeEmit: if (emit) begin
        o_sock_q  <= idx_q;
        o_last_q  <= idx_q == last_sock_q;
        o_share_q <= quo_q;
        o_slot_q  <= (prod_q[63:16] > 48'hFFFF) ? 16'hFFFF : prod_q[31:16];
      end
      default: ;
    endcase
  end

endmodule

### rtl/proportional_share_slot_allocator_core.sv
// ----------------------------------------------------------------------------
// proportional_share_slot_allocator_core: averaged proportional slot sharing
// Top level joining the input stage, the queue and the computing back end.
// ----------------------------------------------------------------------------
// Counts are taken one per cycle while the two-entry queue has room, and the
// back end pops one a cycle while it gathers a round. Once the last count of
// a round is popped, the back end blends each socket's count into its average,
// first multiplying and then summing and storing, and then for each socket sets
// up the bit-serial divider, forms the quotient bits, multiplies by the ticks
// and hands the result over. It pops no count of the next round until the last
// result is handed over. A stalled result holds the back end, and once the
// queue is full the input stalls as well.
module proportional_share_slot_allocator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // byte_count
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // socket_index[2:0], share[19:3], slot_ticks[35:20]
  output logic        m_axis_tlast,   // last_of_round
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i
);
  import psa_pkg::*;

  logic [15:0] weight_q, ticks_q;
  logic [3:0]  sockets_q;
  logic        push, full, pop, empty, restart;
  entry_t      fe_entry, be_entry;
  logic [2:0]  sock;
  logic [16:0] share;
  logic [15:0] slot;

  assign restart = cfg_we_i && (cfg_addr_i == RegSocketsInUse);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q  <= HistoryWeightReset;
      sockets_q <= SocketsReset;
      ticks_q   <= TicksReset;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegHistoryWeight: weight_q  <= cfg_wdata_i;
        RegSocketsInUse:  sockets_q <= cfg_wdata_i[3:0];
        RegTicks:         ticks_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  psa_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .count_i(s_axis_tdata), .sockets_i(sockets_q), .restart_i(restart),
    .push_o(push), .entry_o(fe_entry), .full_i(full)
  );

  psa_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .entry_i(fe_entry), .full_o(full),
    .pop_i(pop), .empty_o(empty), .entry_o(be_entry)
  );

  psa_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .entry_i(be_entry), .pop_o(pop),
    .weight_i(weight_q), .ticks_i(ticks_q),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .sock_o(sock), .share_o(share), .slot_o(slot), .last_o(m_axis_tlast)
  );

  assign m_axis_tdata = {4'd0, slot, share, sock};

endmodule

### rtl/psa_checker.sv
// ----------------------------------------------------------------------------
// psa_checker: port-level checks of the slot allocator
// Watches the result stream for held payloads, sane share values and clear padding.
// ----------------------------------------------------------------------------
module psa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // A stalled result keeps its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // A share never exceeds one whole.
  a_share: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[19:3] <= 17'h10000)
    else $error("share above one");

  // Padding bits stay clear.
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[39:36] == 4'd0)
    else $error("padding set");

endmodule

bind proportional_share_slot_allocator_core psa_checker u_psa_checker (.*);

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the proportional share slot allocator
// Sends byte counts per socket, predicts the averaged shares and slot lengths
// of each completed round, and checks every result item in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import psa_pkg::*;

  // Register index that the block does not implement.
  localparam logic [CfgAddrW-1:0] RegUnknown = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_addr_i = '0;
  logic [15:0] cfg_wdata_i = '0;

  typedef struct packed {
    logic [2:0]  sock;
    logic [16:0] share;
    logic [15:0] ticks;
    logic        last;
  } alloc_t;

  // Predictor state.
  logic [15:0] weight_q;
  logic [3:0]  sockets_q;
  logic [15:0] ticks_q;
  logic [47:0] avg_q [MaxSockets];
  logic [31:0] counts_q [MaxSockets];
  int unsigned pos_q;

  alloc_t      allocs_pending [$];
  int unsigned errors = 0;
  int unsigned checked = 0;
  int unsigned rounds = 0;
  int unsigned cycles = 0;
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned hold_cycles = 0;

  proportional_share_slot_allocator_core uut (.*);

  always #4 clk_i = ~clk_i;

  // Guard against a hung run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 1500000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // Averaging and share computation of one completed round.
  task automatic predict_round();
    int unsigned n;
    logic [63:0] total;
    logic [63:0] fresh;
    logic [63:0] shr;
    logic [63:0] tk;
    alloc_t      a;
    n = (sockets_q == 0) ? 1 : (sockets_q > MaxSockets) ? MaxSockets : sockets_q;
    total = '0;
    for (int i = 0; i < n; i++) begin
      fresh = {32'd0, counts_q[i]} << 16;
      if (avg_q[i] == '0) avg_q[i] = fresh[47:0];
      else avg_q[i] = 48'((64'(weight_q) * avg_q[i]
                           + (64'd65536 - weight_q) * fresh) >> 16);
      total += avg_q[i];
    end
    total &= 64'hF_FFFF_FFFF_FFFF;
    for (int i = 0; i < n; i++) begin
      shr = (total != 0) ? ({16'd0, avg_q[i]} << 16) / total : 0;
      if (shr > 65536) shr = 65536;
      tk = (shr * ticks_q) >> 16;
      if (tk > 16'hFFFF) tk = 16'hFFFF;
      a.sock = 3'(i);
      a.share = shr[16:0];
      a.ticks = tk[15:0];
      a.last = (i + 1 == n);
      allocs_pending.push_back(a);
    end
    rounds++;
  endtask

  task automatic send_count(input logic [31:0] cnt);
    int unsigned n;
    // Offer the item at a later falling edge than the previous withdrawal.
    do @(negedge clk_i); while ($urandom_range(99) < send_idle);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= cnt;
    do @(posedge clk_i); while (!s_axis_tready);
    n = (sockets_q == 0) ? 1 : (sockets_q > MaxSockets) ? MaxSockets : sockets_q;
    if (pos_q >= n) pos_q = 0;
    counts_q[pos_q] = (cnt == 0) ? 32'd1 : cnt;
    pos_q++;
    if (pos_q >= n) begin
      pos_q = 0;
      predict_round();
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  // Wait until every result has arrived, plus the back end's tail.
  task automatic drain();
    while (allocs_pending.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegHistoryWeight: weight_q = val;
      RegSocketsInUse: begin
        sockets_q = val[3:0];
        pos_q = 0;
      end
      RegTicks: ticks_q = val;
      default: ;
    endcase
  endtask

  // Receiver: random stalls, plus an optional long hold-off.
  always @(negedge clk_i) begin
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    alloc_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (allocs_pending.size() == 0) begin
        report("unexpected item", 64'(m_axis_tdata), 64'd0);
      end else begin
        e = allocs_pending.pop_front();
        if (m_axis_tdata[2:0] != e.sock)
          report("socket_index", 64'(m_axis_tdata[2:0]), 64'(e.sock));
        if (m_axis_tdata[19:3] != e.share)
          report("share", 64'(m_axis_tdata[19:3]), 64'(e.share));
        if (m_axis_tdata[35:20] != e.ticks)
          report("slot_ticks", 64'(m_axis_tdata[35:20]), 64'(e.ticks));
        if (m_axis_tlast != e.last)
          report("last_of_round", 64'(m_axis_tlast), 64'(e.last));
        checked++;
      end
    end
  end

  function automatic logic [31:0] random_count();
    case ($urandom_range(3))
      0: return $urandom_range(3);
      1: return $urandom_range(65535);
      2: return 32'hFFFF_FFFF - $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  // Extremes of the count, zero counts, and an unknown register index.
  task automatic test_directed();
    write_reg(RegSocketsInUse, 16'd4);
    send_count(32'd0);
    send_count(32'hFFFF_FFFF);
    send_count(32'd1);
    send_count(32'h5555_AAAA);
    send_count(32'hAAAA_5555);
    send_count(32'd0);
    send_count(32'hFFFF_FFFF);
    send_count(32'd7);
    drain();
    write_reg(RegUnknown, 16'hFFFF);
    write_reg(RegHistoryWeight, 16'd0);
    write_reg(RegTicks, 16'hFFFF);
    repeat (4) send_count(32'd0);
    drain();
    write_reg(RegHistoryWeight, 16'hFFFF);
    write_reg(RegTicks, 16'd1);
    repeat (4) send_count($urandom);
    drain();
  endtask

  // Socket count changes: one, zero, above the maximum, and a dropped partial round.
  task automatic test_socket_counts();
    write_reg(RegTicks, 16'd250);
    write_reg(RegSocketsInUse, 16'd1);
    send_count(32'd12345);
    drain();
    write_reg(RegSocketsInUse, 16'd0);
    send_count(32'd99);
    drain();
    write_reg(RegSocketsInUse, 16'd15);
    repeat (3) send_count($urandom);
    drain();
    repeat (200) @(negedge clk_i);
    write_reg(RegSocketsInUse, 16'd8);
    repeat (8) send_count(random_count());
    drain();
  endtask

  // Random rounds under one idling pattern, with settings changed between phases.
  task automatic test_random(input int unsigned items, input int unsigned s_idle,
                             input int unsigned r_idle);
    send_idle = s_idle;
    recv_idle = r_idle;
    for (int k = 0; k < items; k++) begin
      if (k % 30 == 0) begin
        drain();
        repeat (200) @(negedge clk_i);
        write_reg(RegHistoryWeight, 16'($urandom));
        write_reg(RegTicks, 16'($urandom_range(65535, 1)));
        write_reg(RegSocketsInUse, 16'($urandom_range(8, 1)));
      end
      send_count(random_count());
    end
    drain();
  endtask

  // Receiver holds off while the sender keeps offering items.
  task automatic test_backpressure();
    send_idle = 0;
    recv_idle = 0;
    write_reg(RegSocketsInUse, 16'd8);
    hold_cycles = 600;
    repeat (40) send_count(random_count());
    drain();
  endtask

  initial begin
    weight_q = HistoryWeightReset;
    sockets_q = SocketsReset;
    ticks_q = TicksReset;
    pos_q = 0;
    foreach (avg_q[i]) avg_q[i] = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_socket_counts();
    test_random(70, 27, 81);
    test_random(70, 81, 27);
    test_random(70, 0, 0);
    test_backpressure();
    $display("Covered %0d rounds and %0d result items over weights, socket counts,", rounds,
             checked);
    $display("tick lengths, zero and full-scale counts, and a long output stall.");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
